>>> sv/rtp_timestamp_cross_stream_matcher_unit_assert.svh
// Assertion macros shared by the matcher RTL files.
// No dependencies; assertions are compiled out when SYNTHESIS is defined.
`ifndef RTP_TIMESTAMP_CROSS_STREAM_MATCHER_UNIT_ASSERT_SVH
`define RTP_TIMESTAMP_CROSS_STREAM_MATCHER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RTPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define RTPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RTPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define RTPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> sv/rtpm_pkg.sv
// Types and constants of the RTP timestamp cross-stream matcher.
// Used by every module of the block but rtpm_ram; depends on nothing.
package rtpm_pkg;

    localparam int RTPM_MAX_COMPONENTS = 8;
    localparam int CFG_W   = 4;
    localparam int IDX_W   = 3;
    localparam int TS_W    = 32;
    localparam int CNT_W   = 32;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd2;

    typedef enum logic [2:0] {
        OUT_PENDING = 3'd0,
        OUT_MATCHED = 3'd1,
        OUT_DROPPED = 3'd2,
        OUT_KEPT    = 3'd3,
        OUT_INVALID = 3'd4
    } t_outcome;

    typedef struct packed {
        logic [IDX_W-1:0] component_index;
        logic [TS_W-1:0]  rtp_timestamp;
    } t_in_item;

    typedef struct packed {
        t_outcome         outcome;
        logic [CNT_W-1:0] matched_total;
        logic [CNT_W-1:0] mismatch_total;
    } t_result;

    typedef struct packed {
        logic     load;
        logic     step_k;
        logic     rd_en;
        logic     count_hit;
        logic     finish;
        t_outcome outcome;
    } t_dp_cmd;

    typedef struct packed {
        logic invalid;
        logic walk_end;
        logic candidate;
        logic earlier;
        logic later;
        logic all_hit;
    } t_dp_status;

endpackage

>>> sv/rtpm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rtpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/rtpm_ctrl.sv
// Sequencer of the matcher: walks the components and issues datapath commands.
// Depends on rtpm_pkg and the assertion macro header.
`include "rtp_timestamp_cross_stream_matcher_unit_assert.svh"
module rtpm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  rtpm_pkg::t_dp_status i_status,
    output rtpm_pkg::t_dp_cmd   o_cmd,
    output logic                o_busy
);
    import rtpm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_CMP
    } t_state;

    t_state  r_state, n_state;
    logic    r_busy;
    t_dp_cmd cmd;

    always_comb begin
        n_state       = r_state;
        cmd           = '0;
        cmd.outcome   = OUT_PENDING;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.invalid) begin
                    cmd.finish  = 1'b1;
                    cmd.outcome = OUT_INVALID;
                    n_state     = S_IDLE;
                end else if (i_status.walk_end) begin
                    cmd.finish  = 1'b1;
                    cmd.outcome = i_status.all_hit ? OUT_MATCHED : OUT_PENDING;
                    n_state     = S_IDLE;
                end else if (i_status.candidate) begin
                    cmd.rd_en = 1'b1;
                    n_state   = S_CMP;
                end else begin
                    cmd.step_k = 1'b1;
                end
            end
            S_CMP: begin
                // The earlier test comes first, so a half-range distance drops.
                if (i_status.earlier) begin
                    cmd.finish  = 1'b1;
                    cmd.outcome = OUT_DROPPED;
                    n_state     = S_IDLE;
                end else if (i_status.later) begin
                    cmd.finish  = 1'b1;
                    cmd.outcome = OUT_KEPT;
                    n_state     = S_IDLE;
                end else begin
                    cmd.count_hit = 1'b1;
                    cmd.step_k    = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = r_busy;

    `RTPM_ASSERT_NEXT(a_finish_to_idle, i_clk, i_rst_n, cmd.finish, r_state == S_IDLE && !r_busy, "finish did not return to idle")
    `RTPM_ASSERT_NEXT(a_load_sets_busy, i_clk, i_rst_n, cmd.load, r_busy, "busy not raised after load")
    `RTPM_ASSERT_NOW(a_busy_matches_state, i_clk, i_rst_n, 1'b1, r_busy == (r_state != S_IDLE), "busy out of step with state")
endmodule

>>> sv/rtpm_dp.sv
// Datapath of the matcher: pending flags, timestamp store, walk counter,
// serial comparison, totals and the result register. Depends on rtpm_pkg,
// rtpm_ram and the assertion macro header.
`include "rtp_timestamp_cross_stream_matcher_unit_assert.svh"
module rtpm_dp #(
    parameter int MAX_COMPONENTS = rtpm_pkg::RTPM_MAX_COMPONENTS,
    localparam int AW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rtpm_pkg::t_in_item            i_item,
    input  logic                          i_cfg_we,
    input  logic [rtpm_pkg::CFG_W-1:0]    i_cfg_data,
    input  rtpm_pkg::t_dp_cmd             i_cmd,
    output rtpm_pkg::t_dp_status          o_status,
    output rtpm_pkg::t_result             o_result,
    output logic                          o_done
);
    import rtpm_pkg::*;

    logic [CFG_W-1:0]          r_cfg;
    logic [CFG_W-1:0]          r_neff;
    logic [CFG_W-1:0]          neff_now;
    logic [IDX_W-1:0]          r_idx;
    logic [TS_W-1:0]           r_ts;
    logic [CFG_W-1:0]          r_k;
    logic [CFG_W-1:0]          r_hits;
    logic [MAX_COMPONENTS-1:0] r_pending, n_pending;
    logic [CNT_W-1:0]          r_matched, n_matched;
    logic [CNT_W-1:0]          r_mismatch, n_mismatch;
    t_result                   r_result;
    logic                      r_done;
    logic [TS_W-1:0]           rd_ts;
    logic [TS_W-1:0]           diff_new_old;
    logic [TS_W-1:0]           diff_old_new;
    logic                      load_valid;

    // Effective component count: the register clamped to the store depth.
    always_comb begin
        if (int'(r_cfg) > MAX_COMPONENTS) begin
            neff_now = CFG_W'(MAX_COMPONENTS);
        end else begin
            neff_now = r_cfg;
        end
    end

    assign load_valid = i_cmd.load &&
                        ({1'b0, i_item.component_index} < neff_now);

    rtpm_ram #(
        .WIDTH (TS_W),
        .DEPTH (MAX_COMPONENTS)
    ) u_ts_ram (
        .i_clk   (i_clk),
        .i_we    (load_valid),
        .i_waddr (AW'(i_item.component_index)),
        .i_wdata (i_item.rtp_timestamp),
        .i_re    (i_cmd.rd_en),
        .i_raddr (AW'(r_k)),
        .o_rdata (rd_ts)
    );

    assign diff_new_old = r_ts - rd_ts;
    assign diff_old_new = rd_ts - r_ts;

    always_comb begin
        o_status           = '0;
        o_status.invalid   = ({1'b0, r_idx} >= r_neff);
        o_status.walk_end  = (r_k == r_neff);
        o_status.candidate = (r_k < r_neff) && r_pending[AW'(r_k)] &&
                             (r_k != {1'b0, r_idx});
        o_status.earlier   = diff_new_old[TS_W-1];
        o_status.later     = diff_old_new[TS_W-1];
        o_status.all_hit   = (r_hits == r_neff - CFG_W'(1));
    end

    always_comb begin
        n_pending  = r_pending;
        n_matched  = r_matched;
        n_mismatch = r_mismatch;
        if (i_cmd.finish) begin
            case (i_cmd.outcome)
                OUT_MATCHED: begin
                    n_matched = r_matched + CNT_W'(1);
                    n_pending = '0;
                end
                OUT_DROPPED: begin
                    n_mismatch = r_mismatch + CNT_W'(1);
                    n_pending  = '0;
                end
                OUT_KEPT: begin
                    n_mismatch                = r_mismatch + CNT_W'(1);
                    n_pending                 = '0;
                    n_pending[AW'(r_idx)]     = 1'b1;
                end
                OUT_PENDING: begin
                    n_pending[AW'(r_idx)] = 1'b1;
                end
                default: begin
                    n_pending = r_pending;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg      <= CFG_RESET;
            r_pending  <= '0;
            r_matched  <= '0;
            r_mismatch <= '0;
            r_done     <= 1'b0;
            r_k        <= '0;
            r_hits     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            r_pending  <= n_pending;
            r_matched  <= n_matched;
            r_mismatch <= n_mismatch;
            r_done     <= i_cmd.finish;
            if (i_cmd.load) begin
                r_k    <= '0;
                r_hits <= '0;
            end else begin
                if (i_cmd.step_k) begin
                    r_k <= r_k + CFG_W'(1);
                end
                if (i_cmd.count_hit) begin
                    r_hits <= r_hits + CFG_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx  <= i_item.component_index;
            r_ts   <= i_item.rtp_timestamp;
            r_neff <= neff_now;
        end
        if (i_cmd.finish) begin
            r_result.outcome        <= i_cmd.outcome;
            r_result.matched_total  <= n_matched;
            r_result.mismatch_total <= n_mismatch;
        end
    end

    assign o_result = r_result;
    assign o_done   = r_done;

    `RTPM_ASSERT_NEXT(a_dropped_clears, i_clk, i_rst_n, i_cmd.finish && i_cmd.outcome == OUT_DROPPED, r_pending == '0, "flags left set after a dropped mismatch")
    `RTPM_ASSERT_NEXT(a_kept_single, i_clk, i_rst_n, i_cmd.finish && i_cmd.outcome == OUT_KEPT, $onehot(r_pending), "kept mismatch must leave one flag")
    `RTPM_ASSERT_NEXT(a_invalid_holds, i_clk, i_rst_n, i_cmd.finish && i_cmd.outcome == OUT_INVALID, $stable(r_pending) && $stable(r_matched) && $stable(r_mismatch), "invalid event changed state")
endmodule

>>> sv/rtp_timestamp_cross_stream_matcher_unit.sv
// Top level of the RTP timestamp cross-stream matcher.
// Depends on rtpm_pkg, rtpm_ctrl, rtpm_dp and the assertion macro header.
//
// Events are taken one at a time: start is accepted when busy is low, and
// the result appears on o_result, flagged by o_done for exactly one cycle,
// in the same cycle as busy falls. The receiver cannot stall, so it must
// take every result in that cycle. An event walks the n enabled components
// in turn and spends an extra compare step on each other pending component;
// a compare that finds the new timestamp earlier or later than a stored one
// ends the event, and an invalid index ends it at the first scan step. The
// walk reads one stored timestamp per compare from a store with a single
// read port and registered read data. A configuration transfer is taken
// only while busy is low.
`include "rtp_timestamp_cross_stream_matcher_unit_assert.svh"
module rtp_timestamp_cross_stream_matcher_unit #(
    parameter int MAX_COMPONENTS = rtpm_pkg::RTPM_MAX_COMPONENTS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  rtpm_pkg::t_in_item         i_item,
    output logic                       o_done,
    output rtpm_pkg::t_result          o_result,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [rtpm_pkg::CFG_W-1:0] i_cfg_data
);
    import rtpm_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       ctrl_busy;

    rtpm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (ctrl_busy)
    );

    rtpm_dp #(
        .MAX_COMPONENTS (MAX_COMPONENTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_valid && !ctrl_busy),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_result   (o_result),
        .o_done     (o_done)
    );

    assign busy        = ctrl_busy;
    assign o_cfg_ready = !ctrl_busy;

    `RTPM_ASSERT_NOW(a_done_not_busy, i_clk, i_rst_n, o_done, !busy, "result shown while still busy")
    `RTPM_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy || o_done, "accepted event neither busy nor done")
    `RTPM_ASSERT_NOW(a_done_after_busy, i_clk, i_rst_n, o_done, $past(busy) || $past(start), "result without an event")
endmodule
